// ----- hdl/manchester_link_lock_and_ber_defines.svh -----
// Assertion macros shared by the link checker.
`ifndef MANCHESTER_LINK_LOCK_AND_BER_DEFINES_SVH
`define MANCHESTER_LINK_LOCK_AND_BER_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define MLB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define MLB_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/mlb_pkg.sv -----
// Types, constants and helper functions for the Manchester link endpoint.
package mlb_pkg;

    localparam int HEADER_BYTES = 2;
    localparam int DATA_BYTES   = 32;
    localparam int FRAME_LEN    = HEADER_BYTES + DATA_BYTES;
    localparam int POS_W        = $clog2(FRAME_LEN);
    localparam int REF_W        = (DATA_BYTES > 1) ? $clog2(DATA_BYTES) : 1;
    localparam int STORE_DEPTH  = 32;
    localparam int STORE_AW     = $clog2(STORE_DEPTH);
    localparam int SAMPLE_W     = 10;
    localparam int BYTE_W       = 8;
    localparam int ERR_W        = 32;
    localparam int POP_W        = 4;

    localparam int S_TDATA_W    = 56;
    localparam int S_TUSER_W    = 2;
    localparam int M_TDATA_W    = 48;
    localparam int M_TUSER_W    = 1;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 8;

    localparam logic [7:0] MASK_FIRST     = 8'h80;
    localparam logic [1:0] RX_LAST_PAIR   = 2'd3;
    localparam logic [7:0] NULL_HS_RESET  = 8'h55;
    localparam logic [7:0] DATA_HS_RESET  = 8'hAA;
    localparam logic [7:0] LOCK_TGT_RESET = 8'd8;

    typedef enum logic [1:0] {
        LINK_SEARCH  = 2'd0,
        LINK_LOCKED  = 2'd1,
        LINK_RUNNING = 2'd2
    } link_t;

    typedef enum logic [1:0] {
        KIND_TICK    = 2'd0,
        KIND_SAMPLE  = 2'd1,
        KIND_LOAD    = 2'd2,
        KIND_RESTART = 2'd3
    } kind_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_NULL_HS     = 2'd0,
        CFG_DATA_HS     = 2'd1,
        CFG_LOCK_TARGET = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0] null_hs;
        logic [7:0] data_hs;
        logic [7:0] lock_target;
    } cfg_t;

    typedef struct packed {
        kind_t                 kind;
        logic [SAMPLE_W-1:0]   first_a;
        logic [SAMPLE_W-1:0]   first_b;
        logic [SAMPLE_W-1:0]   second_a;
        logic [SAMPLE_W-1:0]   second_b;
        logic [STORE_AW-1:0]   load_index;
        logic [BYTE_W-1:0]     load_value;
    } item_t;

    typedef struct packed {
        link_t              link;
        logic [7:0]         null_run;
        logic [POS_W-1:0]   tx_pos;
        logic [7:0]         tx_mask;
        logic               tx_second;
        logic               laser;
        logic [POS_W-1:0]   rx_pos;
        logic [1:0]         rx_pair;
        logic [7:0]         rx_accum;
        logic [REF_W-1:0]   ref_pos;
        logic [ERR_W-1:0]   errors;
    } state_t;

    typedef struct packed {
        logic               laser_level;
        logic               byte_done;
        logic [BYTE_W-1:0]  received_byte;
        link_t              lock_state;
        logic [ERR_W-1:0]   bit_errors;
    } result_t;

    localparam state_t STATE_RESET = '{
        link:      LINK_SEARCH,
        null_run:  8'd0,
        tx_pos:    '0,
        tx_mask:   MASK_FIRST,
        tx_second: 1'b0,
        laser:     1'b0,
        rx_pos:    '0,
        rx_pair:   2'd0,
        rx_accum:  8'd0,
        ref_pos:   '0,
        errors:    '0
    };

    function automatic logic [POP_W-1:0] popcount8(input logic [7:0] v);
        logic [POP_W-1:0] n;
        n = '0;
        for (int i = 0; i < 8; i++) begin
            n = n + POP_W'(v[i]);
        end
        return n;
    endfunction

    function automatic logic [POS_W-1:0] pos_inc(input logic [POS_W-1:0] p);
        return (p == POS_W'(FRAME_LEN - 1)) ? '0 : p + POS_W'(1);
    endfunction

    function automatic logic [STORE_AW-1:0] tx_store_addr(input logic [POS_W-1:0] p);
        logic [POS_W+STORE_AW-1:0] off;
        off = {{STORE_AW{1'b0}}, p} - (POS_W+STORE_AW)'(HEADER_BYTES);
        return off[STORE_AW-1:0];
    endfunction

    function automatic logic [STORE_AW-1:0] ref_store_addr(input logic [REF_W-1:0] r);
        logic [REF_W+STORE_AW-1:0] ext;
        ext = {{STORE_AW{1'b0}}, r};
        return ext[STORE_AW-1:0];
    endfunction

endpackage

// ----- hdl/manchester_link_lock_and_ber.sv -----
// Top level of the Manchester optical link endpoint with lock and bit error count.
// Takes one transaction per cycle unless a result stalls on m_tready, and returns one
// result per transaction, held in the input register and then in the result register.
// All per-transaction work (Manchester half-bit, sample-pair decisions, lock state
// machine, popcount error update) is a single combinational step between the two.
// The 32-byte reference store is a RAM read at the transmit and receive reference
// positions; reads are issued from the next state, so the bytes are ready at the next
// transaction, with a write-through path for a load to the same entry. Reading an
// entry never loaded gives an undefined byte. A result stalled on m_tready still lets
// one more transaction enter the input register.
module manchester_link_lock_and_ber (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [mlb_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [mlb_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // first_bit_sample_a, first_bit_sample_b, second_bit_sample_a,
    // second_bit_sample_b, load_index, load_value, zero pad
    input  logic [mlb_pkg::S_TDATA_W-1:0]    s_tdata,
    // kind
    input  logic [mlb_pkg::S_TUSER_W-1:0]    s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // laser_level, received_byte, lock_state, bit_errors, zero pad
    output logic [mlb_pkg::M_TDATA_W-1:0]    m_tdata,
    // byte_done
    output logic [mlb_pkg::M_TUSER_W-1:0]    m_tuser
);

    mlb_pkg::cfg_t    cfg_reg;
    mlb_pkg::cfg_t    cfg_next;
    mlb_pkg::item_t   in_item;
    mlb_pkg::item_t   in_reg;
    logic             in_valid_reg;
    logic             out_valid_reg;
    mlb_pkg::result_t out_reg;
    mlb_pkg::state_t  state_reg;
    mlb_pkg::state_t  step_next;
    mlb_pkg::state_t  state_next;
    mlb_pkg::state_t  state_rd;
    mlb_pkg::result_t step_res;
    logic             advance;
    logic             s_accept;
    logic             ram_we;

    logic [mlb_pkg::STORE_AW-1:0] tx_addr_next;
    logic [mlb_pkg::STORE_AW-1:0] rx_addr_next;
    logic [mlb_pkg::BYTE_W-1:0]   tx_ram_data;
    logic [mlb_pkg::BYTE_W-1:0]   rx_ram_data;
    logic [mlb_pkg::BYTE_W-1:0]   byp_data_reg;
    logic                         tx_byp_hit_reg;
    logic                         rx_byp_hit_reg;
    logic [mlb_pkg::BYTE_W-1:0]   ref_tx_byte;
    logic [mlb_pkg::BYTE_W-1:0]   ref_rx_byte;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_item.kind       = mlb_pkg::kind_t'(s_tuser);
        in_item.first_a    = s_tdata[9:0];
        in_item.first_b    = s_tdata[19:10];
        in_item.second_a   = s_tdata[29:20];
        in_item.second_b   = s_tdata[39:30];
        in_item.load_index = s_tdata[44:40];
        in_item.load_value = s_tdata[52:45];
    end

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                mlb_pkg::CFG_NULL_HS:     cfg_next.null_hs     = cfg_wdata;
                mlb_pkg::CFG_DATA_HS:     cfg_next.data_hs     = cfg_wdata;
                mlb_pkg::CFG_LOCK_TARGET: cfg_next.lock_target = cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.null_hs     <= mlb_pkg::NULL_HS_RESET;
            cfg_reg.data_hs     <= mlb_pkg::DATA_HS_RESET;
            cfg_reg.lock_target <= mlb_pkg::LOCK_TGT_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_reg <= in_item;
        end
    end

    assign ref_tx_byte = tx_byp_hit_reg ? byp_data_reg : tx_ram_data;
    assign ref_rx_byte = rx_byp_hit_reg ? byp_data_reg : rx_ram_data;

    mlb_step u_step (
        .st          (state_reg),
        .item        (in_reg),
        .cfg         (cfg_reg),
        .ref_tx_byte (ref_tx_byte),
        .ref_rx_byte (ref_rx_byte),
        .st_next     (step_next),
        .res         (step_res)
    );

    assign state_next = advance ? step_next : state_reg;
    assign state_rd   = aresetn ? state_next : mlb_pkg::STATE_RESET;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mlb_pkg::STATE_RESET;
        end else begin
            state_reg <= state_next;
        end
    end

    assign ram_we       = advance && (in_reg.kind == mlb_pkg::KIND_LOAD);
    assign tx_addr_next = mlb_pkg::tx_store_addr(state_rd.tx_pos);
    assign rx_addr_next = mlb_pkg::ref_store_addr(state_rd.ref_pos);

    mlb_ram #(
        .WIDTH (mlb_pkg::BYTE_W),
        .DEPTH (mlb_pkg::STORE_DEPTH)
    ) u_ref_ram (
        .aclk      (aclk),
        .wr_en     (ram_we),
        .wr_addr   (in_reg.load_index),
        .wr_data   (in_reg.load_value),
        .rd_addr_a (tx_addr_next),
        .rd_data_a (tx_ram_data),
        .rd_addr_b (rx_addr_next),
        .rd_data_b (rx_ram_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tx_byp_hit_reg <= 1'b0;
            rx_byp_hit_reg <= 1'b0;
        end else begin
            tx_byp_hit_reg <= ram_we && (in_reg.load_index == tx_addr_next);
            rx_byp_hit_reg <= ram_we && (in_reg.load_index == rx_addr_next);
        end
    end

    always_ff @(posedge aclk) begin
        byp_data_reg <= in_reg.load_value;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= step_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_reg.bit_errors, out_reg.lock_state,
                       out_reg.received_byte, out_reg.laser_level};
    assign m_tuser  = out_reg.byte_done;

endmodule

// ----- hdl/mlb_ram.sv -----
// Generic single-write, dual-read RAM with registered read data.
module mlb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic [WIDTH-1:0]         rd_data_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_a <= mem_reg[rd_addr_a];
        rd_data_b <= mem_reg[rd_addr_b];
    end

endmodule

// ----- hdl/mlb_step.sv -----
// Per-transaction next-state and result logic of the link endpoint.
module mlb_step (
    input  mlb_pkg::state_t           st,
    input  mlb_pkg::item_t            item,
    input  mlb_pkg::cfg_t             cfg,
    input  logic [mlb_pkg::BYTE_W-1:0] ref_tx_byte,
    input  logic [mlb_pkg::BYTE_W-1:0] ref_rx_byte,
    output mlb_pkg::state_t           st_next,
    output mlb_pkg::result_t          res
);

    logic [7:0]                 src_byte;
    logic                       tx_bit;
    logic [7:0]                 mask_rot;
    logic                       hi_bit;
    logic                       lo_bit;
    logic [2:0]                 pair_shift;
    logic [7:0]                 accum_new;
    logic                       byte_done;
    logic                       err_en;
    logic [7:0]                 err_ref;
    logic [mlb_pkg::POP_W-1:0]  err_add;
    logic [7:0]                 run_inc;

    always_comb begin
        case (st.link)
            mlb_pkg::LINK_RUNNING: begin
                if (st.tx_pos == '0) begin
                    src_byte = cfg.data_hs;
                end else if (st.tx_pos < mlb_pkg::POS_W'(mlb_pkg::HEADER_BYTES)) begin
                    src_byte = 8'd0;
                end else begin
                    src_byte = ref_tx_byte;
                end
            end
            mlb_pkg::LINK_LOCKED: begin
                src_byte = (st.tx_pos == '0) ? cfg.data_hs : cfg.null_hs;
            end
            default: begin
                src_byte = cfg.null_hs;
            end
        endcase
    end

    assign tx_bit     = |(src_byte & st.tx_mask);
    assign mask_rot   = {st.tx_mask[0], st.tx_mask[7:1]};
    assign hi_bit     = item.first_a < item.first_b;
    assign lo_bit     = item.second_a < item.second_b;
    assign pair_shift = 3'd6 - {st.rx_pair, 1'b0};
    assign accum_new  = st.rx_accum | (8'({hi_bit, lo_bit}) << pair_shift);
    assign byte_done  = (item.kind == mlb_pkg::KIND_SAMPLE) && (st.rx_pair == mlb_pkg::RX_LAST_PAIR);
    assign run_inc    = st.null_run + 8'd1;

    always_comb begin
        case (st.link)
            mlb_pkg::LINK_RUNNING: begin
                err_en  = st.rx_pos >= mlb_pkg::POS_W'(mlb_pkg::HEADER_BYTES);
                err_ref = ref_rx_byte;
            end
            mlb_pkg::LINK_LOCKED, mlb_pkg::LINK_SEARCH: begin
                err_en  = 1'b1;
                err_ref = cfg.null_hs;
            end
            default: begin
                err_en  = 1'b0;
                err_ref = cfg.null_hs;
            end
        endcase
    end

    assign err_add = mlb_pkg::popcount8(accum_new ^ err_ref);

    always_comb begin
        st_next = st;
        case (item.kind)
            mlb_pkg::KIND_TICK: begin
                if (st.tx_second) begin
                    st_next.laser     = tx_bit;
                    st_next.tx_mask   = mask_rot;
                    st_next.tx_second = 1'b0;
                    if (mask_rot[7]) begin
                        st_next.tx_pos = mlb_pkg::pos_inc(st.tx_pos);
                    end
                end else begin
                    st_next.laser     = ~tx_bit;
                    st_next.tx_second = 1'b1;
                end
            end
            mlb_pkg::KIND_SAMPLE: begin
                st_next.rx_pair  = st.rx_pair + 2'd1;
                st_next.rx_accum = accum_new;
                if (byte_done) begin
                    st_next.rx_accum = 8'd0;
                    st_next.rx_pos   = mlb_pkg::pos_inc(st.rx_pos);
                    if (err_en) begin
                        st_next.errors = st.errors + mlb_pkg::ERR_W'(err_add);
                    end
                    case (st.link)
                        mlb_pkg::LINK_RUNNING: begin
                            if (err_en) begin
                                st_next.ref_pos =
                                    (st.ref_pos == mlb_pkg::REF_W'(mlb_pkg::DATA_BYTES - 1)) ?
                                    '0 : st.ref_pos + mlb_pkg::REF_W'(1);
                            end else if (st.rx_pos == '0 && accum_new != cfg.data_hs) begin
                                st_next.link     = mlb_pkg::LINK_SEARCH;
                                st_next.null_run = 8'd0;
                            end
                        end
                        mlb_pkg::LINK_LOCKED: begin
                            if (accum_new == cfg.data_hs) begin
                                st_next.tx_pos    = '0;
                                st_next.tx_mask   = mlb_pkg::MASK_FIRST;
                                st_next.tx_second = 1'b0;
                                st_next.rx_pos    = mlb_pkg::POS_W'(1);
                                st_next.ref_pos   = '0;
                                st_next.link      = mlb_pkg::LINK_RUNNING;
                            end else if (accum_new != cfg.null_hs) begin
                                st_next.link     = mlb_pkg::LINK_SEARCH;
                                st_next.null_run = 8'd0;
                            end
                        end
                        mlb_pkg::LINK_SEARCH: begin
                            if (accum_new == cfg.null_hs) begin
                                st_next.null_run = run_inc;
                                if (run_inc == cfg.lock_target) begin
                                    st_next.link = mlb_pkg::LINK_LOCKED;
                                end
                            end else begin
                                st_next.null_run = 8'd0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            mlb_pkg::KIND_RESTART: begin
                st_next.link      = mlb_pkg::LINK_SEARCH;
                st_next.laser     = 1'b0;
                st_next.null_run  = 8'd0;
                st_next.tx_pos    = '0;
                st_next.tx_mask   = mlb_pkg::MASK_FIRST;
                st_next.tx_second = 1'b0;
                st_next.rx_pos    = '0;
                st_next.rx_pair   = 2'd0;
                st_next.rx_accum  = 8'd0;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        res.laser_level   = st_next.laser;
        res.byte_done     = byte_done;
        res.received_byte = byte_done ? accum_new : 8'd0;
        res.lock_state    = st_next.link;
        res.bit_errors    = st_next.errors;
    end

endmodule

// ----- hdl/mlb_checker.sv -----
// Port-level checks for the Manchester link endpoint, bound to the top level.
`include "manchester_link_lock_and_ber_defines.svh"

module mlb_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             cfg_wr_en,
    input logic [mlb_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input logic [mlb_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [mlb_pkg::S_TDATA_W-1:0]    s_tdata,
    input logic [mlb_pkg::S_TUSER_W-1:0]    s_tuser,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [mlb_pkg::M_TDATA_W-1:0]    m_tdata,
    input logic [mlb_pkg::M_TUSER_W-1:0]    m_tuser
);

    `MLB_ASSERT_NXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
    `MLB_ASSERT_IMP(a_byte_zero, m_tvalid && !m_tuser[0], m_tdata[8:1] == 8'd0, "received byte set without byte done")
    `MLB_ASSERT_NXT(a_err_hold, m_tvalid && m_tready, !(m_tvalid && !m_tuser[0]) || (m_tdata[42:11] == $past(m_tdata[42:11])), "error count moved without a byte")
    `MLB_ASSERT_NXT(a_no_skip_lock, m_tvalid && m_tready, !(m_tvalid && m_tdata[10:9] == 2'd2) || ($past(m_tdata[10:9]) != 2'd0), "running entered straight from searching")

endmodule

bind manchester_link_lock_and_ber mlb_checker u_mlb_checker (.*);

// ----- tb/manchester_link_lock_and_ber_tb.sv -----
// Testbench for the Manchester link endpoint: lock, framing and bit error count.
`timescale 1ns / 1ps

module manchester_link_lock_and_ber_tb;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 4;
    localparam int REPORT_MAX   = 10;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [mlb_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [mlb_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [mlb_pkg::S_TDATA_W-1:0]   s_tdata   = '0;
    logic [mlb_pkg::S_TUSER_W-1:0]   s_tuser   = '0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [mlb_pkg::M_TDATA_W-1:0]   m_tdata;
    logic [mlb_pkg::M_TUSER_W-1:0]   m_tuser;

    manchester_link_lock_and_ber u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #2 aclk = ~aclk;

    // link model state
    logic [7:0]      hs_null;
    logic [7:0]      hs_data;
    logic [7:0]      lock_need;
    mlb_pkg::link_t  cur_link;
    logic [7:0]      run_len;
    int              tx_idx;
    int              rx_idx;
    int              cmp_idx;
    logic [7:0]      tx_bitsel;
    logic            tx_late_half;
    logic            laser_now;
    logic [1:0]      rx_pairs;
    logic [7:0]      rx_shift_reg;
    logic [31:0]     err_count;
    logic [7:0]      golden [0:mlb_pkg::STORE_DEPTH-1];

    mlb_pkg::result_t expected_status [$];
    int              mismatch_total = 0;
    int              items_sent     = 0;
    int              burst_left     = 0;
    bit              no_gaps        = 1'b0;
    int              hold_req       = 0;
    int              hold_left      = 0;
    int              mode_left      = 0;
    int              rx_mode        = 0;
    int              cycle_count    = 0;

    function automatic void relink();
        cur_link     = mlb_pkg::LINK_SEARCH;
        laser_now    = 1'b0;
        run_len      = 8'd0;
        tx_idx       = 0;
        tx_bitsel    = mlb_pkg::MASK_FIRST;
        tx_late_half = 1'b0;
        rx_idx       = 0;
        rx_pairs     = 2'd0;
        rx_shift_reg = 8'd0;
    endfunction

    function automatic void reset_link_model();
        hs_null   = mlb_pkg::NULL_HS_RESET;
        hs_data   = mlb_pkg::DATA_HS_RESET;
        lock_need = mlb_pkg::LOCK_TGT_RESET;
        relink();
        cmp_idx   = 0;
        err_count = '0;
    endfunction

    function automatic void go_search();
        cur_link = mlb_pkg::LINK_SEARCH;
        run_len  = 8'd0;
    endfunction

    function automatic logic [7:0] frame_byte();
        if (cur_link == mlb_pkg::LINK_RUNNING) begin
            if (tx_idx == 0)
                return hs_data;
            if (tx_idx < mlb_pkg::HEADER_BYTES)
                return 8'h00;
            return golden[(tx_idx - mlb_pkg::HEADER_BYTES) % mlb_pkg::STORE_DEPTH];
        end
        if (cur_link == mlb_pkg::LINK_LOCKED && tx_idx == 0)
            return hs_data;
        return hs_null;
    endfunction

    function automatic void laser_half_bit();
        logic cur_bit;
        cur_bit = (frame_byte() & tx_bitsel) != 8'h00;
        if (tx_late_half) begin
            laser_now    = cur_bit;
            tx_bitsel    = {tx_bitsel[0], tx_bitsel[7:1]};
            tx_late_half = 1'b0;
            if (tx_bitsel[7])
                tx_idx = (tx_idx + 1) % mlb_pkg::FRAME_LEN;
        end else begin
            laser_now    = ~cur_bit;
            tx_late_half = 1'b1;
        end
    endfunction

    function automatic void take_rx_byte(logic [7:0] b);
        case (cur_link)
            mlb_pkg::LINK_RUNNING: begin
                if (rx_idx < mlb_pkg::HEADER_BYTES) begin
                    if (rx_idx == 0 && b != hs_data)
                        go_search();
                end else begin
                    err_count = err_count
                        + 32'($countones(b ^ golden[cmp_idx % mlb_pkg::STORE_DEPTH]));
                    cmp_idx   = (cmp_idx + 1) % mlb_pkg::DATA_BYTES;
                end
            end
            mlb_pkg::LINK_LOCKED: begin
                if (b == hs_data) begin
                    tx_idx       = 0;
                    tx_bitsel    = mlb_pkg::MASK_FIRST;
                    tx_late_half = 1'b0;
                    rx_idx       = 0;
                    cmp_idx      = 0;
                    cur_link     = mlb_pkg::LINK_RUNNING;
                end else if (b != hs_null) begin
                    go_search();
                end
                err_count = err_count + 32'($countones(b ^ hs_null));
            end
            default: begin
                if (b == hs_null) begin
                    run_len = run_len + 8'd1;
                    if (run_len == lock_need)
                        cur_link = mlb_pkg::LINK_LOCKED;
                end else begin
                    run_len = 8'd0;
                end
                err_count = err_count + 32'($countones(b ^ hs_null));
            end
        endcase
        rx_idx       = (rx_idx + 1) % mlb_pkg::FRAME_LEN;
        rx_shift_reg = 8'd0;
    endfunction

    function automatic mlb_pkg::result_t advance_link(mlb_pkg::kind_t k,
            logic [mlb_pkg::SAMPLE_W-1:0] fa, fb, sa, sb,
            logic [mlb_pkg::STORE_AW-1:0] li, logic [7:0] lv);
        mlb_pkg::result_t r;
        logic             done;
        logic [7:0]       got;
        done = 1'b0;
        got  = 8'd0;
        case (k)
            mlb_pkg::KIND_TICK: laser_half_bit();
            mlb_pkg::KIND_SAMPLE: begin
                rx_shift_reg = rx_shift_reg
                    | ({6'd0, fa < fb, sa < sb} << (6 - 2 * rx_pairs));
                rx_pairs     = rx_pairs + 2'd1;
                if (rx_pairs == 2'd0) begin
                    done = 1'b1;
                    got  = rx_shift_reg;
                    take_rx_byte(got);
                end
            end
            mlb_pkg::KIND_LOAD: golden[li] = lv;
            default: relink();
        endcase
        r.laser_level   = laser_now;
        r.byte_done     = done;
        r.received_byte = got;
        r.lock_state    = cur_link;
        r.bit_errors    = err_count;
        return r;
    endfunction

    function automatic string show_status(mlb_pkg::result_t r);
        return $sformatf("laser=%0b done=%0b byte=%02h link=%0d errors=%0d",
                         r.laser_level, r.byte_done, r.received_byte, r.lock_state,
                         r.bit_errors);
    endfunction

    // result checker
    always @(posedge aclk) begin : check_results
        mlb_pkg::result_t got;
        mlb_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.laser_level   = m_tdata[0];
            got.received_byte = m_tdata[8:1];
            got.lock_state    = mlb_pkg::link_t'(m_tdata[10:9]);
            got.bit_errors    = m_tdata[42:11];
            got.byte_done     = m_tuser[0];
            if (expected_status.size() == 0) begin
                mismatch_total++;
                if (mismatch_total <= REPORT_MAX)
                    $display("%0t: unexpected result: %s", $realtime, show_status(got));
            end else begin
                want = expected_status.pop_front();
                if (got.laser_level !== want.laser_level || got.byte_done !== want.byte_done
                        || got.received_byte !== want.received_byte
                        || got.lock_state !== want.lock_state
                        || got.bit_errors !== want.bit_errors) begin
                    mismatch_total++;
                    if (mismatch_total <= REPORT_MAX)
                        $display("%0t: mismatch: expected %s, got %s", $realtime,
                                 show_status(want), show_status(got));
                end
            end
        end
    end

    // receiver stall pattern and hold-off
    always @(negedge aclk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = $urandom_range(3, 0);
                mode_left = $urandom_range(80, 8);
            end
            mode_left--;
            case (rx_mode)
                2:       m_tready <= 1'($urandom_range(1, 0));
                3:       m_tready <= ($urandom_range(3, 0) == 0);
                default: m_tready <= 1'b1;
            endcase
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[manchester_link_lock_and_ber] ERROR");
            $finish;
        end
    end

    task automatic send_item(mlb_pkg::kind_t k, logic [mlb_pkg::SAMPLE_W-1:0] fa, fb, sa, sb,
                             logic [mlb_pkg::STORE_AW-1:0] li, logic [7:0] lv);
        int gap;
        if (!no_gaps && burst_left == 0) begin
            gap = $urandom_range(4, 0);
            repeat (gap) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
            end
            burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(60, 20)
                                                     : $urandom_range(12, 1);
        end
        if (burst_left > 0)
            burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= k;
        s_tdata  <= mlb_pkg::S_TDATA_W'({lv, li, sb, sa, fb, fa});
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        expected_status.push_back(advance_link(k, fa, fb, sa, sb, li, lv));
        items_sent++;
    endtask

    task automatic idle_tx();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    task automatic drain_results();
        while (expected_status.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(mlb_pkg::cfg_reg_t idx, logic [7:0] v);
        idle_tx();
        drain_results();
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            mlb_pkg::CFG_NULL_HS: hs_null   = v;
            mlb_pkg::CFG_DATA_HS: hs_data   = v;
            default:              lock_need = v;
        endcase
    endtask

    task automatic send_tick();
        send_item(mlb_pkg::KIND_TICK, mlb_pkg::SAMPLE_W'($urandom),
                  mlb_pkg::SAMPLE_W'($urandom), mlb_pkg::SAMPLE_W'($urandom),
                  mlb_pkg::SAMPLE_W'($urandom), mlb_pkg::STORE_AW'($urandom),
                  8'($urandom));
    endtask

    task automatic send_restart();
        send_item(mlb_pkg::KIND_RESTART, mlb_pkg::SAMPLE_W'($urandom),
                  mlb_pkg::SAMPLE_W'($urandom), mlb_pkg::SAMPLE_W'($urandom),
                  mlb_pkg::SAMPLE_W'($urandom), mlb_pkg::STORE_AW'($urandom),
                  8'($urandom));
    endtask

    task automatic send_load(logic [mlb_pkg::STORE_AW-1:0] li, logic [7:0] lv);
        send_item(mlb_pkg::KIND_LOAD, mlb_pkg::SAMPLE_W'($urandom),
                  mlb_pkg::SAMPLE_W'($urandom), mlb_pkg::SAMPLE_W'($urandom),
                  mlb_pkg::SAMPLE_W'($urandom), li, lv);
    endtask

    task automatic send_samples(logic [mlb_pkg::SAMPLE_W-1:0] fa, fb, sa, sb);
        send_item(mlb_pkg::KIND_SAMPLE, fa, fb, sa, sb, mlb_pkg::STORE_AW'($urandom),
                  8'($urandom));
    endtask

    task automatic pick_levels(logic one, output logic [mlb_pkg::SAMPLE_W-1:0] a, b);
        if (one) begin
            a = mlb_pkg::SAMPLE_W'($urandom_range(1022, 0));
            b = mlb_pkg::SAMPLE_W'($urandom_range(1023, a + 1));
        end else if ($urandom_range(7, 0) == 0) begin
            a = mlb_pkg::SAMPLE_W'($urandom_range(1023, 0));
            b = a;
        end else begin
            b = mlb_pkg::SAMPLE_W'($urandom_range(1023, 0));
            a = mlb_pkg::SAMPLE_W'($urandom_range(1023, b));
        end
    endtask

    task automatic send_pair(logic hi, logic lo);
        logic [mlb_pkg::SAMPLE_W-1:0] fa, fb, sa, sb;
        pick_levels(hi, fa, fb);
        pick_levels(lo, sa, sb);
        send_samples(fa, fb, sa, sb);
    endtask

    task automatic send_filler();
        int r;
        r = $urandom_range(99, 0);
        if (r < 30)
            repeat ($urandom_range(3, 1)) send_tick();
        else if (r < 33)
            send_load(mlb_pkg::STORE_AW'($urandom), 8'($urandom));
        else if (r < 34)
            send_restart();
    endtask

    task automatic send_rx_byte(logic [7:0] b, bit mixed);
        for (int i = 7; i > 0; i -= 2) begin
            if (mixed)
                send_filler();
            send_pair(b[i], b[i-1]);
        end
    endtask

    function automatic logic [7:0] next_line_byte();
        int r;
        r = $urandom_range(99, 0);
        case (cur_link)
            mlb_pkg::LINK_LOCKED: begin
                if (r < 60)
                    return hs_data;
                if (r < 85)
                    return hs_null;
                return 8'($urandom);
            end
            mlb_pkg::LINK_RUNNING: begin
                if (rx_idx == 0)
                    return (r < 90) ? hs_data : 8'($urandom);
                if (rx_idx < mlb_pkg::HEADER_BYTES)
                    return 8'($urandom);
                return golden[cmp_idx % mlb_pkg::STORE_DEPTH]
                       ^ ((r < 75) ? 8'h00 : 8'($urandom));
            end
            default: return (r < 88) ? hs_null : 8'($urandom);
        endcase
    endfunction

    task automatic test_reference_load();
        for (int i = 0; i < mlb_pkg::STORE_DEPTH; i++)
            send_load(mlb_pkg::STORE_AW'(i),
                      (i == 0) ? 8'h00 :
                      (i == mlb_pkg::STORE_DEPTH - 1) ? 8'hFF : 8'($urandom));
    endtask

    task automatic test_sample_edges();
        repeat (3) send_tick();
        send_samples(10'd0, 10'd1023, 10'd1023, 10'd0);
        send_samples(10'd1023, 10'd1023, 10'd0, 10'd0);
        send_samples(10'd1022, 10'd1023, 10'd0, 10'd1);
        send_samples(10'd512, 10'd511, 10'd1023, 10'd1022);
        send_load(mlb_pkg::STORE_AW'(mlb_pkg::STORE_DEPTH - 1), 8'hFF);
        send_load('0, 8'h00);
        send_pair(1'b1, 1'b0);
        send_restart();
        send_rx_byte(hs_null, 1'b0);
        send_tick();
        send_restart();
        send_tick();
    endtask

    // lowered target sits below the current run, so the run counter passes it
    task automatic test_target_below_run();
        write_reg(mlb_pkg::CFG_LOCK_TARGET, 8'd255);
        send_restart();
        repeat (6) send_rx_byte(hs_null, 1'b0);
        write_reg(mlb_pkg::CFG_LOCK_TARGET, 8'd2);
        repeat (3) send_rx_byte(hs_null, 1'b0);
        write_reg(mlb_pkg::CFG_LOCK_TARGET, 8'd0);
        repeat (2) send_rx_byte(hs_null, 1'b0);
        write_reg(mlb_pkg::CFG_LOCK_TARGET, 8'd12);
        send_rx_byte(hs_null, 1'b0);
        send_rx_byte(hs_data, 1'b0);
        repeat (6) send_tick();
        send_restart();
    endtask

    task automatic test_random_link_traffic();
        logic [7:0] v;
        int         phase_start;
        for (int phase = 0; phase < 4; phase++) begin
            v = 8'($urandom);
            case (phase)
                0: begin
                    write_reg(mlb_pkg::CFG_NULL_HS, 8'h00);
                    write_reg(mlb_pkg::CFG_DATA_HS, 8'hFF);
                    write_reg(mlb_pkg::CFG_LOCK_TARGET, 8'd1);
                end
                1: begin
                    write_reg(mlb_pkg::CFG_NULL_HS, 8'hFF);
                    write_reg(mlb_pkg::CFG_DATA_HS, 8'h00);
                    write_reg(mlb_pkg::CFG_LOCK_TARGET, 8'd2);
                end
                2: begin
                    write_reg(mlb_pkg::CFG_NULL_HS, v);
                    write_reg(mlb_pkg::CFG_DATA_HS, v);
                    write_reg(mlb_pkg::CFG_LOCK_TARGET, 8'd1);
                end
                default: begin
                    write_reg(mlb_pkg::CFG_NULL_HS, v);
                    write_reg(mlb_pkg::CFG_DATA_HS, 8'($urandom));
                    write_reg(mlb_pkg::CFG_LOCK_TARGET, 8'($urandom_range(4, 1)));
                end
            endcase
            if ($urandom_range(1, 0) == 1)
                send_restart();
            phase_start = items_sent;
            while (items_sent - phase_start < 140)
                send_rx_byte(next_line_byte(), 1'b1);
        end
    endtask

    task automatic test_output_backpressure();
        idle_tx();
        drain_results();
        no_gaps  = 1'b1;
        hold_req = 300;
        repeat (40) begin
            if ($urandom_range(1, 0) == 1)
                send_tick();
            else
                send_pair(1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        reset_link_model();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reference_load();
        test_sample_edges();
        test_target_below_run();
        test_random_link_traffic();
        test_output_backpressure();

        idle_tx();
        drain_results();
        repeat (20) @(posedge aclk);
        if (mismatch_total == 0)
            $display("[manchester_link_lock_and_ber] OK");
        else
            $display("[manchester_link_lock_and_ber] ERROR");
        $finish;
    end

endmodule
